[rtl/core/htbd_pkg.sv]
package htbd_pkg;

  // Default sizes of the node table and of the longest code word.
  localparam int unsigned MAX_NODES_DEF    = 512;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  // Fixed field widths of the stream items.
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned S_DATA_W   = 48;
  localparam int unsigned M_DATA_W   = 8;
  localparam int unsigned STATUS_W   = 2;

  // Depth of the queue between the intake and the tree walker.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PATH = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC_WAIT,
    S_LOAD_STEP,
    S_LOAD_WAIT
  } walk_state_t;

  // One classified input item as it sits in the queue.
  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  symbol;
    logic              bit_in;
  } item_t;

  // Head of the queue as seen by the tree walker.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

[rtl/core/htbd_front.sv]
module htbd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // code_bits[31:0], code_length[37:32], symbol[45:38], bit_in[46], zero pad[47]
  input  logic [htbd_pkg::S_DATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]                    s_axis_tuser,
  output htbd_pkg::queue_head_t         head,
  input  logic                          pop
);

  localparam int unsigned QAW = (htbd_pkg::QUEUE_DEPTH > 1) ? $clog2(htbd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(htbd_pkg::QUEUE_DEPTH + 1);

  htbd_pkg::item_t  q [htbd_pkg::QUEUE_DEPTH];
  htbd_pkg::item_t  in_item;
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             do_pop;

  // Split the beat into its fields and classify the command.
  always_comb begin
    in_item.cmd         = htbd_pkg::cmd_t'(s_axis_tuser[0]);
    in_item.code_bits   = s_axis_tdata[31:0];
    in_item.code_length = s_axis_tdata[37:32];
    in_item.symbol      = s_axis_tdata[45:38];
    in_item.bit_in      = s_axis_tdata[46];
  end

  assign s_axis_tready = (count != CW'(htbd_pkg::QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign do_pop        = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(htbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(htbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/htbd_walk.sv]
module htbd_walk #(
  parameter int unsigned MAX_NODES    = htbd_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  htbd_pkg::queue_head_t         head,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // symbol_out[7:0]
  output logic [htbd_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [htbd_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned UW = $clog2(MAX_NODES + 1);
  localparam int unsigned KW = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned SW = htbd_pkg::SYM_W;
  localparam int unsigned EW = 2 * NW + 1 + SW;

  htbd_pkg::walk_state_t state, state_next;

  // Node table; entry zero lives in the root registers instead.
  logic [EW-1:0] mem [MAX_NODES];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic [NW-1:0] rd_addr;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [NW-1:0] root_l, root_r;
  logic [NW-1:0] cur, cur_next;
  logic [NW-1:0] cache_l, cache_l_next;
  logic [NW-1:0] cache_r, cache_r_next;
  logic [UW-1:0] nodes_used, nodes_used_next;
  logic [NW-1:0] child, child_next;
  logic [NW-1:0] p, p_next;
  logic [NW-1:0] pe_l, pe_l_next;
  logic [NW-1:0] pe_r, pe_r_next;
  logic          pe_lv, pe_lv_next;
  logic [SW-1:0] pe_lab, pe_lab_next;
  logic [KW-1:0] k, k_next;
  logic [htbd_pkg::CODE_W-1:0] code_bits, code_bits_next;
  logic [SW-1:0] symbol, symbol_next;

  logic          out_valid;
  logic [SW-1:0] out_sym;
  logic [htbd_pkg::STATUS_W-1:0] out_st;
  logic          emit;
  logic [SW-1:0] emit_sym;
  htbd_pkg::status_t emit_st;

  logic          can_take;
  logic          head_dec;
  logic [NW-1:0] cur_l_eff, cur_r_eff, cur_kid;
  logic [6:0]    len_ext;
  logic [KW-1:0] len_sat;
  logic [6:0]    pos;
  logic          load_bit;
  logic [NW-1:0] slot;
  logic          table_full;
  logic          k_zero;
  logic [NW-1:0] rd_l, rd_r;
  logic          rd_lv;
  logic [SW-1:0] rd_lab;
  logic [NW-1:0] new_node;

  // Shared conditions for the state machine and the datapath.
  assign can_take   = head.valid && !out_valid;
  assign head_dec   = (head.item.cmd == htbd_pkg::CMD_DECODE);
  assign cur_l_eff  = (cur == '0) ? root_l : cache_l;
  assign cur_r_eff  = (cur == '0) ? root_r : cache_r;
  assign cur_kid    = head.item.bit_in ? cur_r_eff : cur_l_eff;
  assign len_ext    = {1'b0, head.item.code_length};
  assign len_sat    = (len_ext > 7'(MAX_CODE_LEN)) ? KW'(MAX_CODE_LEN) : KW'(len_ext);
  assign pos        = 7'(k) - 7'd1;
  assign load_bit   = (pos < 7'd32) ? code_bits[pos[4:0]] : 1'b0;
  assign slot       = load_bit ? pe_r : pe_l;
  assign table_full = (nodes_used == UW'(MAX_NODES));
  assign k_zero     = (k == '0);
  assign new_node   = nodes_used[NW-1:0];
  assign rd_l       = rd_data[EW-1 -: NW];
  assign rd_r       = rd_data[EW-NW-1 -: NW];
  assign rd_lv      = rd_data[SW];
  assign rd_lab     = rd_data[SW-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      htbd_pkg::S_IDLE: begin
        if (can_take) begin
          if (head_dec) begin
            state_next = (cur_kid != '0) ? htbd_pkg::S_DEC_WAIT : htbd_pkg::S_IDLE;
          end else begin
            state_next = htbd_pkg::S_LOAD_STEP;
          end
        end
      end
      htbd_pkg::S_DEC_WAIT: begin
        state_next = htbd_pkg::S_IDLE;
      end
      htbd_pkg::S_LOAD_STEP: begin
        if (k_zero) begin
          state_next = htbd_pkg::S_IDLE;
        end else if (slot != '0) begin
          state_next = htbd_pkg::S_LOAD_WAIT;
        end else if (table_full) begin
          state_next = htbd_pkg::S_IDLE;
        end
      end
      htbd_pkg::S_LOAD_WAIT: begin
        state_next = htbd_pkg::S_LOAD_STEP;
      end
      default: state_next = htbd_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory strobes for each state.
  always_comb begin
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = child;
    wr_en           = 1'b0;
    wr_addr         = p;
    wr_data         = {pe_l, pe_r, pe_lv, pe_lab};
    emit            = 1'b0;
    emit_sym        = '0;
    emit_st         = htbd_pkg::ST_OK;
    cur_next        = cur;
    cache_l_next    = cache_l;
    cache_r_next    = cache_r;
    nodes_used_next = nodes_used;
    child_next      = child;
    p_next          = p;
    pe_l_next       = pe_l;
    pe_r_next       = pe_r;
    pe_lv_next      = pe_lv;
    pe_lab_next     = pe_lab;
    k_next          = k;
    code_bits_next  = code_bits;
    symbol_next     = symbol;
    unique case (state)
      htbd_pkg::S_IDLE: begin
        if (can_take) begin
          pop = 1'b1;
          if (head_dec) begin
            if (cur_kid == '0) begin
              emit     = 1'b1;
              emit_st  = htbd_pkg::ST_BAD_PATH;
              cur_next = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = cur_kid;
              child_next = cur_kid;
            end
          end else begin
            // Start a load walk at the root.
            code_bits_next = head.item.code_bits;
            symbol_next    = head.item.symbol;
            k_next         = len_sat;
            p_next         = '0;
            pe_l_next      = root_l;
            pe_r_next      = root_r;
            pe_lv_next     = 1'b0;
            pe_lab_next    = '0;
          end
        end
      end
      htbd_pkg::S_DEC_WAIT: begin
        if (rd_lv) begin
          emit     = 1'b1;
          emit_sym = rd_lab;
          emit_st  = htbd_pkg::ST_OK;
          cur_next = '0;
        end else begin
          cur_next     = child;
          cache_l_next = rd_l;
          cache_r_next = rd_r;
        end
      end
      htbd_pkg::S_LOAD_STEP: begin
        if (k_zero) begin
          // End of the code word: label the node.
          wr_en   = 1'b1;
          wr_data = {pe_l, pe_r, 1'b1, symbol};
        end else if (slot != '0) begin
          rd_en   = 1'b1;
          rd_addr = slot;
          p_next  = slot;
          k_next  = k - 1'b1;
        end else if (table_full) begin
          // Store the node as it stands; a freshly made node gets its empty entry.
          wr_en    = 1'b1;
          emit     = 1'b1;
          emit_st  = htbd_pkg::ST_FULL;
          cur_next = '0;
        end else begin
          // Create the missing child and link it into the parent entry.
          wr_en           = 1'b1;
          wr_data         = load_bit ? {pe_l, new_node, pe_lv, pe_lab}
                                     : {new_node, pe_r, pe_lv, pe_lab};
          nodes_used_next = nodes_used + 1'b1;
          p_next          = new_node;
          pe_l_next       = '0;
          pe_r_next       = '0;
          pe_lv_next      = 1'b0;
          pe_lab_next     = '0;
          k_next          = k - 1'b1;
        end
      end
      htbd_pkg::S_LOAD_WAIT: begin
        pe_l_next   = rd_l;
        pe_r_next   = rd_r;
        pe_lv_next  = rd_lv;
        pe_lab_next = rd_lab;
      end
      default: ;
    endcase
    // Keep the cached children of the current node in step with table writes.
    if (wr_en && (wr_addr == cur) && (cur != '0)) begin
      cache_l_next = wr_data[EW-1 -: NW];
      cache_r_next = wr_data[EW-NW-1 -: NW];
    end
  end

  // Node table write port.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Node table read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htbd_pkg::S_IDLE;
      cur        <= '0;
      nodes_used <= UW'(1);
      root_l     <= '0;
      root_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      nodes_used <= nodes_used_next;
      if (wr_en && (wr_addr == '0)) begin
        root_l <= wr_data[EW-1 -: NW];
        root_r <= wr_data[EW-NW-1 -: NW];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk registers and the result register.
  always_ff @(posedge clk) begin
    cache_l   <= cache_l_next;
    cache_r   <= cache_r_next;
    child     <= child_next;
    p         <= p_next;
    pe_l      <= pe_l_next;
    pe_r      <= pe_r_next;
    pe_lv     <= pe_lv_next;
    pe_lab    <= pe_lab_next;
    k         <= k_next;
    code_bits <= code_bits_next;
    symbol    <= symbol_next;
    if (emit) begin
      out_sym <= emit_sym;
      out_st  <= emit_st;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sym;
  assign m_axis_tuser  = out_st;

endmodule

[rtl/core/huffman_tree_bit_decoder_unit.sv]
// Bitwise Huffman decoder over a node table of MAX_NODES entries. A beat with
// command 0 loads one code word: the walk starts at the root, creates missing
// children and labels the last node with the symbol; it gives no result unless
// the table runs full, which gives status 2 and returns decoding to the root.
// A beat with command 1 steps the decoder by one stream bit and gives a result
// when it lands on a labelled node (status 0 with the symbol) or on a missing
// child (status 1); both return to the root. Input beats go into a two-entry
// queue, so the block keeps taking beats while a result waits on the output
// until the queue is full. A decode bit with a missing child gives its result
// straight from the idle state; any other decode bit waits for the registered
// read of the node table. A load starts at the root, creates each missing node
// and reads each existing node it passes through from the table, then writes
// the label. A beat is taken from the queue only once the output register is
// empty. No clearing pass is needed after reset: the root sits in registers
// and every other entry is written by the load that creates its node.
module huffman_tree_bit_decoder_unit #(
  parameter int unsigned MAX_NODES    = htbd_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // code_bits[31:0], code_length[37:32], symbol[45:38], bit_in[46], zero pad[47]
  input  logic [htbd_pkg::S_DATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // symbol_out[7:0]
  output logic [htbd_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [htbd_pkg::STATUS_W-1:0] m_axis_tuser
);

  htbd_pkg::queue_head_t head;
  logic                  pop;

  // Intake and queue.
  htbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head          (head),
    .pop           (pop)
  );

  // Tree walker with the node table and the result register.
  htbd_walk #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[rtl/core/htbd_checker.sv]
module htbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [htbd_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [htbd_pkg::STATUS_W-1:0] m_axis_tuser
);

  // A stalled result beat holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Only the three defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == htbd_pkg::ST_OK) ||
                      (m_axis_tuser == htbd_pkg::ST_BAD_PATH) ||
                      (m_axis_tuser == htbd_pkg::ST_FULL))
    else $error("undefined status code");

  // Error results carry a zero symbol.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != htbd_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("error result with a nonzero symbol");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");

endmodule

bind huffman_tree_bit_decoder_unit htbd_checker u_htbd_checker (.*);

[test/huffman_tree_bit_decoder_unit_tb.sv]
module huffman_tree_bit_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = htbd_pkg::MAX_NODES_DEF;
  localparam int CODE_MAX    = htbd_pkg::MAX_CODE_LEN_DEF;
  localparam int RAND_ITEMS  = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int LIMIT       = 1000000;
  // From this many nodes on, new random code words stop so the fill comes last.
  localparam int GROW_STOP   = 380;

  typedef logic [$clog2(NODES)-1:0] node_idx_t;

  typedef struct packed {
    logic [htbd_pkg::SYM_W-1:0] sym;
    htbd_pkg::status_t          st;
  } decoded_t;

  // Keeps its own copy of the code tree and the results it must produce.
  class symbol_scoreboard;
    node_idx_t                  left_kid [NODES];
    node_idx_t                  right_kid [NODES];
    bit                         labelled [NODES];
    logic [htbd_pkg::SYM_W-1:0] label_of [NODES];
    int unsigned                used;
    node_idx_t                  cur;
    decoded_t                   expected_symbols [$];
    int                         errors;

    function new();
      for (int i = 0; i < NODES; i++) begin
        left_kid[i]  = '0;
        right_kid[i] = '0;
        labelled[i]  = 1'b0;
        label_of[i]  = '0;
      end
      used   = 1;
      cur    = '0;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void queue_result(logic [htbd_pkg::SYM_W-1:0] sym, htbd_pkg::status_t st);
      decoded_t r;
      r.sym = sym;
      r.st  = st;
      expected_symbols.push_back(r);
    endfunction

    // Apply one accepted input beat to the tree and queue any result it causes.
    function void note_beat(htbd_pkg::cmd_t cmd, logic [htbd_pkg::CODE_W-1:0] word,
                            logic [htbd_pkg::LEN_W-1:0] len,
                            logic [htbd_pkg::SYM_W-1:0] sym, logic bit_in);
      node_idx_t next;
      node_idx_t node;
      int        depth;
      bit        stop;
      if (cmd == htbd_pkg::CMD_DECODE) begin
        next = bit_in ? right_kid[cur] : left_kid[cur];
        if (next == '0) begin
          cur = '0;
          queue_result('0, htbd_pkg::ST_BAD_PATH);
        end else if (labelled[next]) begin
          cur = '0;
          queue_result(label_of[next], htbd_pkg::ST_OK);
        end else begin
          cur = next;
        end
      end else begin
        depth = (len > CODE_MAX) ? CODE_MAX : int'(len);
        node  = '0;
        stop  = 1'b0;
        // Walk from the root, first code bit at the highest used bit of the word.
        for (int k = depth; k > 0 && !stop; k--) begin
          next = word[k-1] ? right_kid[node] : left_kid[node];
          if (next == '0) begin
            if (used >= NODES) begin
              stop = 1'b1;
              cur  = '0;
              queue_result('0, htbd_pkg::ST_FULL);
            end else begin
              next = node_idx_t'(used);
              if (word[k-1]) begin
                right_kid[node] = next;
              end else begin
                left_kid[node] = next;
              end
              left_kid[next]  = '0;
              right_kid[next] = '0;
              labelled[next]  = 1'b0;
              label_of[next]  = '0;
              used++;
            end
          end
          node = next;
        end
        if (!stop) begin
          labelled[node] = 1'b1;
          label_of[node] = sym;
        end
      end
    endfunction

    // Compare one output beat with the oldest pending result.
    task check_beat(logic [htbd_pkg::M_DATA_W-1:0] data,
                    logic [htbd_pkg::STATUS_W-1:0] user);
      decoded_t want;
      if (expected_symbols.size() == 0) begin
        report($sformatf("result with nothing pending: symbol %0d status %0d", data, user));
      end else begin
        want = expected_symbols.pop_front();
        if (user !== want.st) begin
          report($sformatf("status %0d, wanted %0d", user, want.st));
        end
        if (data !== want.sym) begin
          report($sformatf("symbol %0d, wanted %0d", data, want.sym));
        end
      end
    endtask
  endclass

  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [htbd_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]                    s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [htbd_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic [htbd_pkg::STATUS_W-1:0] m_axis_tuser;

  logic steady  = 1'b0;
  logic hold_go = 1'b0;
  logic hold    = 1'b0;
  int   cycles  = 0;
  int   sent    = 0;

  logic [htbd_pkg::CODE_W-1:0] code_book_word [$];
  logic [htbd_pkg::LEN_W-1:0]  code_book_len [$];

  symbol_scoreboard sb = new();

  huffman_tree_bit_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random stalls, none during the steady stretch, and a full stall during a hold-off.
  always @(posedge clk) begin
    if (rst || hold) begin
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 29);
    end
  end

  // Long hold-off on the output so the input queue fills and stalls.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one input beat, after idle cycles drawn one at a time, and wait for acceptance.
  task automatic send_beat(input htbd_pkg::cmd_t cmd,
                           input logic [htbd_pkg::CODE_W-1:0] word,
                           input logic [htbd_pkg::LEN_W-1:0] len,
                           input logic [htbd_pkg::SYM_W-1:0] sym,
                           input logic bit_in);
    while (!steady && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, bit_in, sym, len, word};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(cmd, word, len, sym, bit_in);
    sent++;
  endtask

  task automatic send_load(input logic [htbd_pkg::CODE_W-1:0] word,
                           input logic [htbd_pkg::LEN_W-1:0] len,
                           input logic [htbd_pkg::SYM_W-1:0] sym);
    send_beat(htbd_pkg::CMD_LOAD, word, len, sym, 1'($urandom));
  endtask

  task automatic send_decode(input logic bit_in);
    send_beat(htbd_pkg::CMD_DECODE, $urandom, 6'($urandom_range(63)), 8'($urandom),
              bit_in);
  endtask

  // Load a code word and remember it for well-formed decode streams.
  task automatic load_code(input logic [htbd_pkg::CODE_W-1:0] word,
                           input logic [htbd_pkg::LEN_W-1:0] len,
                           input logic [htbd_pkg::SYM_W-1:0] sym);
    send_load(word, len, sym);
    if (len != 0) begin
      code_book_word.push_back(word);
      code_book_len.push_back((len > CODE_MAX) ? htbd_pkg::LEN_W'(CODE_MAX) : len);
    end
  endtask

  // Feed the bits of one known code word, first bit first.
  task automatic send_code(input int idx);
    for (int k = code_book_len[idx]; k > 0; k--) begin
      send_decode(code_book_word[idx][k-1]);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3)) send_decode(1'($urandom));
  endtask

  initial begin
    int pick;
    int roll;
    logic [htbd_pkg::LEN_W-1:0] len;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty tree: both directions are missing children.
    send_decode(1'b0);
    send_decode(1'b1);
    // A zero-length code labels the root, which decoding never looks at.
    load_code(32'h1234_5678, 6'd0, 8'hA5);
    send_decode(1'b1);
    // A labelled node that also has children; bits above the length are junk.
    load_code(32'hFFFF_FFF6, 6'd4, 8'h11);
    load_code(32'h5555_551A, 6'd6, 8'h22);
    send_code(0);
    // Relabel the same path.
    load_code(32'h0000_0006, 6'd4, 8'h33);
    send_code(0);
    // Missing child part way down.
    send_decode(1'b0);
    send_decode(1'b1);
    send_decode(1'b0);
    // Longest code words, and lengths past the limit that saturate.
    load_code(32'hFFFF_FFFF, 6'd32, 8'hFF);
    load_code(32'h0000_0000, 6'd32, 8'h00);
    load_code(32'hFFFF_FFFF, 6'd63, 8'h5A);
    load_code(32'hAAAA_AAAA, 6'd33, 8'h01);

    // Random part: mostly whole code words, some loads and some noise bits.
    while (sent < RAND_ITEMS) begin
      steady <= (sent >= 600 && sent < 900);
      if (sent >= 150 && !hold_go) begin
        hold_go <= 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        if (sb.used < GROW_STOP && $urandom_range(3) != 0) begin
          len = ($urandom_range(19) == 0) ? 6'd0 : 6'($urandom_range(3, 10));
          load_code($urandom, len, 8'($urandom));
        end else begin
          pick = $urandom_range(code_book_word.size() - 1);
          send_load(code_book_word[pick], code_book_len[pick], 8'($urandom));
        end
      end else if (roll < 82) begin
        send_code($urandom_range(code_book_word.size() - 1));
      end else begin
        send_noise();
      end
    end
    steady <= 1'b0;

    // Fill the node table, then keep loading new paths into the full table.
    while (sb.used < NODES) begin
      load_code($urandom, 6'd32, 8'($urandom));
    end
    repeat (6) send_load($urandom, 6'd32, 8'($urandom));
    // A relabel still works once the table is full.
    send_load(code_book_word[1], code_book_len[1], 8'($urandom));
    repeat (20) begin
      if ($urandom_range(3) == 0) begin
        send_noise();
      end else begin
        send_code($urandom_range(code_book_word.size() - 1));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_symbols.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/htbd_pkg.sv
rtl/core/htbd_front.sv
rtl/core/htbd_walk.sv
rtl/core/huffman_tree_bit_decoder_unit.sv
rtl/core/htbd_checker.sv
test/huffman_tree_bit_decoder_unit_tb.sv
